[rtl/rlmp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmp_pkg: shared types and helpers of the line max plot unit
// Grid geometry, request and result types, command and register codes, and
// the cell address and grid bound helpers used by the datapath.
// ----------------------------------------------------------------------------
package rlmp_pkg;

	// Grid capacity; coordinates of a request are always eight bits wide.
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(CELLS);

	localparam int COORD_W  = 8;
	localparam int HEIGHT_W = 32;
	localparam int GRID_W   = 9;
	localparam int COUNT_W  = 9;
	localparam int CFG_IDX_W = 2;
	// Bresenham error term: covers -2*255 .. 2*255 with margin.
	localparam int D_W      = COORD_W + 3;

	// Command codes.
	localparam logic CMD_PLOT = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

	localparam logic [GRID_W-1:0] GRID_WIDTH_RST  = 9'd256;
	localparam logic [GRID_W-1:0] GRID_HEIGHT_RST = 9'd256;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [ADDR_W-1:0]  addr_t;

	typedef struct packed {
		logic                       cmd;
		coord_t                     x_start;
		coord_t                     y_start;
		coord_t                     x_end;
		coord_t                     y_end;
		logic signed [HEIGHT_W-1:0] height;
	} req_t;

	typedef struct packed {
		logic signed [HEIGHT_W-1:0] cell_height;
		logic                       cell_marked;
		logic [COUNT_W-1:0]         pixels_written;
		logic                       off_grid;
	} res_t;

	// Current position of the line walker.
	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
	} walk_pos_t;

	// Memory entry of cell (x, y).
	function automatic addr_t cell_addr(input coord_t x, input coord_t y);
		cell_addr = ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x);
	endfunction

	// A cell is on the grid when it is below both the register and the capacity.
	function automatic logic in_grid(input coord_t x, input coord_t y,
			input logic [GRID_W-1:0] gw, input logic [GRID_W-1:0] gh);
		in_grid = (32'(x) < 32'(gw)) && (32'(x) < 32'(MAX_WIDTH)) &&
			(32'(y) < 32'(gh)) && (32'(y) < 32'(MAX_HEIGHT));
	endfunction

endpackage

[rtl/rlmp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmp_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rlmp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/rlmp_walk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmp_walk: Bresenham line walker
// Loads a segment, picks the major axis and the lower end, then advances one
// cell per step request until the stop coordinate is reached.
// ----------------------------------------------------------------------------
module rlmp_walk
	import rlmp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  logic      adv,
	input  req_t      seg,
	output walk_pos_t pos
);

	logic                  steep_q;
	logic                  dir_up_q;
	coord_t                x_q;
	coord_t                y_q;
	coord_t                stop_q;
	logic signed [D_W-1:0] d_q;
	logic signed [D_W-1:0] inc_a_q;
	logic signed [D_W-1:0] inc_b_q;

	coord_t                dx;
	coord_t                dy;
	coord_t                major;
	coord_t                minor;
	logic                  steep;
	logic                  swap;
	coord_t                bx;
	coord_t                by;
	coord_t                ox;
	coord_t                oy;
	logic signed [D_W-1:0] two_minor;
	logic signed [D_W-1:0] two_major;

	// Segment setup: axis choice, lower end, direction and error terms.
	always_comb begin
		dx    = (seg.x_end > seg.x_start) ? seg.x_end - seg.x_start : seg.x_start - seg.x_end;
		dy    = (seg.y_end > seg.y_start) ? seg.y_end - seg.y_start : seg.y_start - seg.y_end;
		steep = dy > dx;
		major = steep ? dy : dx;
		minor = steep ? dx : dy;
		swap  = steep ? (seg.y_start > seg.y_end) : (seg.x_start > seg.x_end);
		bx    = swap ? seg.x_end : seg.x_start;
		by    = swap ? seg.y_end : seg.y_start;
		ox    = swap ? seg.x_start : seg.x_end;
		oy    = swap ? seg.y_start : seg.y_end;
		two_minor = $signed({2'b00, minor, 1'b0});
		two_major = $signed({2'b00, major, 1'b0});
	end

	// Control state of the walker.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steep_q  <= 1'b0;
			dir_up_q <= 1'b0;
			x_q      <= '0;
			y_q      <= '0;
			stop_q   <= '0;
			d_q      <= '0;
			inc_a_q  <= '0;
			inc_b_q  <= '0;
		end else if (load) begin
			steep_q  <= steep;
			dir_up_q <= steep ? (ox > bx) : (oy > by);
			x_q      <= bx;
			y_q      <= by;
			stop_q   <= steep ? oy : ox;
			d_q      <= two_minor - $signed({3'b000, major});
			inc_a_q  <= two_minor;
			inc_b_q  <= two_minor - two_major;
		end else if (adv) begin
			// Major axis always moves; minor axis moves when the error is not negative.
			if (d_q < 0) begin
				d_q <= d_q + inc_a_q;
			end else begin
				d_q <= d_q + inc_b_q;
			end
			if (steep_q) begin
				y_q <= y_q + 1'b1;
				if (d_q >= 0) begin
					x_q <= dir_up_q ? x_q + 1'b1 : x_q - 1'b1;
				end
			end else begin
				x_q <= x_q + 1'b1;
				if (d_q >= 0) begin
					y_q <= dir_up_q ? y_q + 1'b1 : y_q - 1'b1;
				end
			end
		end
	end

	assign pos.x    = x_q;
	assign pos.y    = y_q;
	assign pos.last = steep_q ? (y_q == stop_q) : (x_q == stop_q);

endmodule

[rtl/raster_line_max_plot_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_line_max_plot_unit: height grid line rasterizer with maximum merge
// Walks a segment with Bresenham stepping and merges a height into each cell
// by read-modify-write of a height memory and a mark memory.
//
// Channel   Signals                              Direction
// request   start, busy, req                     in (busy out)
// result    done, result                         out, one-cycle strobe
// config    cfg_valid, cfg_ready, cfg_index,     in (cfg_ready out)
//           cfg_data
//
// A plot runs from acceptance through a setup state, then one cell per cycle
// through the single read port of the memories, then a drain state for the
// last write-back. A read runs through the setup state and a read-data state.
// After reset the mark memory is cleared one entry per cycle, over all CELLS
// entries, with busy high; configuration writes are taken throughout.
// The result is shown for exactly one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module raster_line_max_plot_unit
	import rlmp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  done,
	output res_t                  result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [GRID_W-1:0]     cfg_data
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;
	localparam logic [2:0] ST_WALK  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_RDATA = 3'd5;

	logic [2:0]         state_q;
	addr_t              clr_addr_q;
	logic [GRID_W-1:0]  grid_width_q;
	logic [GRID_W-1:0]  grid_height_q;
	req_t               req_q;
	logic [COUNT_W-1:0] count_q;
	logic               off_q;
	logic               rd_ing_q;
	logic               done_q;
	res_t               result_q;

	logic  wr_s1;
	addr_t addr_s1;

	walk_pos_t pos;
	logic      walk_load;
	logic      walk_adv;

	coord_t            rd_x;
	coord_t            rd_y;
	logic              rd_ing;
	logic              rd_en;
	addr_t             rd_addr;
	logic [0:0]        mark_rdata;
	logic [HEIGHT_W-1:0] h_rdata;
	logic              clearing;
	logic              mark_we;
	addr_t             mark_waddr;
	logic [0:0]        mark_wdata;
	logic signed [HEIGHT_W-1:0] merged_h;

	assign busy      = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;
	assign clearing  = state_q == ST_CLEAR;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Line walker.
	assign walk_load = (state_q == ST_SETUP) && (req_q.cmd == CMD_PLOT);
	assign walk_adv  = (state_q == ST_WALK) && !pos.last;

	rlmp_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (walk_load),
		.adv    (walk_adv),
		.seg    (req_q),
		.pos    (pos)
	);

	// Read side: the walker position while walking, the read cell otherwise.
	always_comb begin
		rd_x    = (state_q == ST_WALK) ? pos.x : req_q.x_start;
		rd_y    = (state_q == ST_WALK) ? pos.y : req_q.y_start;
		rd_ing  = in_grid(rd_x, rd_y, grid_width_q, grid_height_q);
		rd_addr = cell_addr(rd_x, rd_y);
		rd_en   = rd_ing && ((state_q == ST_WALK) ||
			((state_q == ST_SETUP) && (req_q.cmd == CMD_READ)));
	end

	// Write-back: an unmarked cell takes the new height, a marked one the maximum.
	always_comb begin
		if (mark_rdata[0] && ($signed(h_rdata) > req_q.height)) begin
			merged_h = $signed(h_rdata);
		end else begin
			merged_h = req_q.height;
		end
		mark_we    = clearing || wr_s1;
		mark_waddr = clearing ? clr_addr_q : addr_s1;
		mark_wdata = clearing ? 1'b0 : 1'b1;
	end

	rlmp_ram #(
		.WIDTH (HEIGHT_W),
		.DEPTH (CELLS)
	) u_height_ram (
		.clk   (clk),
		.we    (wr_s1),
		.waddr (addr_s1),
		.wdata (merged_h),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (h_rdata)
	);

	rlmp_ram #(
		.WIDTH (1),
		.DEPTH (CELLS)
	) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (mark_rdata)
	);

	// Request register; held for the whole command.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= req;
		end
	end

	// Write-back stage address.
	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
	end

	// Sequencer: clearing pass, setup, walk, drain and read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			count_q    <= '0;
			off_q      <= 1'b0;
			rd_ing_q   <= 1'b0;
			wr_s1      <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			wr_s1  <= (state_q == ST_WALK) && rd_ing;
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					count_q  <= '0;
					off_q    <= 1'b0;
					rd_ing_q <= rd_ing;
					state_q  <= (req_q.cmd == CMD_READ) ? ST_RDATA : ST_WALK;
				end
				ST_WALK: begin
					if (rd_ing) begin
						count_q <= count_q + 1'b1;
					end else begin
						off_q <= 1'b1;
					end
					if (pos.last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_RDATA: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register, loaded in the cycle before the strobe.
	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN) begin
			result_q.cell_height    <= '0;
			result_q.cell_marked    <= 1'b0;
			result_q.pixels_written <= count_q;
			result_q.off_grid       <= off_q;
		end else if (state_q == ST_RDATA) begin
			result_q.cell_height    <= (rd_ing_q && mark_rdata[0]) ? $signed(h_rdata) : '0;
			result_q.cell_marked    <= rd_ing_q && mark_rdata[0];
			result_q.pixels_written <= '0;
			result_q.off_grid       <= !rd_ing_q;
		end
	end

endmodule
